/* rtl/core/nrcs_pkg.sv */
// Package for the nearest resource cell search block.
// Holds grid geometry, class and kind codes, and the structs shared by the modules.
`default_nettype none
package nrcs_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int MAX_RADIUS  = 15;
    localparam int X_W         = 6;
    localparam int Y_W         = 6;
    localparam int ADDR_W      = X_W + Y_W;
    localparam int DEPTH       = GRID_WIDTH * GRID_HEIGHT;
    localparam int RAD_W       = 4;
    localparam int OFF_W       = RAD_W + 1;
    localparam int POS_W       = X_W + 2;
    localparam int DIST_W      = 9;
    localparam int CLASS_W     = 3;
    localparam int KIND_W      = 2;
    localparam int DATA_W      = 24;

    localparam logic [RAD_W-1:0] RESET_RADIUS = 4'd3;

    localparam logic [CLASS_W-1:0] CLASS_WALKABLE = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_TREE     = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_BOULDER  = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_IRON_ORE = 3'd5;

    localparam logic [KIND_W-1:0] KIND_TREE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BOULDER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IRON_ORE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [CLASS_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } ram_ctrl_t;

    typedef struct packed {
        logic              vld;
        logic              in_grid;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [DIST_W-1:0] dsq;
    } probe_t;

    typedef struct packed {
        logic              start;
        logic              use_pref;
        logic [KIND_W-1:0] pref;
    } query_t;

    typedef struct packed {
        logic ready;
        logic out_load;
        logic clearing;
    } seq_stat_t;

    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] kind;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [DIST_W-1:0] dsq;
    } best_t;

    function automatic logic [KIND_W-1:0] kind_of_class(input logic [CLASS_W-1:0] cls);
        logic [KIND_W-1:0] k;
        unique case (cls)
            CLASS_TREE:     k = KIND_TREE;
            CLASS_BOULDER:  k = KIND_BOULDER;
            CLASS_IRON_ORE: k = KIND_IRON_ORE;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/nrcs_grid_ram.sv */
// Grid class store: one write port, one read port with registered read data.
// Depends on nrcs_pkg for depth and widths.
`default_nettype none
module nrcs_grid_ram
    import nrcs_pkg::*;
(
    input  wire logic               clk,
    input  wire ram_ctrl_t          ctrl,
    output logic [CLASS_W-1:0]      rdata
);

    logic [CLASS_W-1:0] grid_mem [DEPTH];
    logic [CLASS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            grid_mem[ctrl.waddr] <= ctrl.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= grid_mem[ctrl.raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/core/nrcs_seq.sv */
// Sequencer: clearing pass, cell writes and the window scan of a query.
// Depends on nrcs_pkg; drives nrcs_grid_ram and feeds probes to nrcs_best_unit.
`default_nettype none
module nrcs_seq
    import nrcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              mode,
    input  wire logic [X_W-1:0]    cell_x,
    input  wire logic [Y_W-1:0]    cell_y,
    input  wire logic [CLASS_W-1:0] cell_class,
    input  wire logic              use_preference,
    input  wire logic [KIND_W-1:0] pref_kind,
    input  wire logic [RAD_W-1:0]  search_radius,
    input  wire logic              out_free,
    output ram_ctrl_t              ram_ctrl,
    output probe_t                 probe,
    output query_t                 query,
    output seq_stat_t              stat
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam logic [RAD_W-1:0]  MAX_R  = RAD_W'(MAX_RADIUS);
    localparam logic [POS_W-1:0]  GW_POS = POS_W'(GRID_WIDTH);
    localparam logic [POS_W-1:0]  GH_POS = POS_W'(GRID_HEIGHT);

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [OFF_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [RAD_W-1:0]  r_reg;
    logic [X_W-1:0]    cx_reg;
    logic [Y_W-1:0]    cy_reg;
    logic              use_pref_reg;
    logic [KIND_W-1:0] pref_reg;
    probe_t            probe_reg, probe_next;

    logic              accept;
    logic              q_start;
    logic [RAD_W-1:0]  r_sat;
    logic [OFF_W-1:0]  neg_r_in, r_off;
    logic [POS_W-1:0]  xs, ys;
    logic [OFF_W-1:0]  adx, ady;
    logic [7:0]        sqx, sqy;
    logic              out_load;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign q_start = accept && (mode == MODE_QUERY);
    assign r_sat   = (search_radius > MAX_R) ? MAX_R : search_radius;
    assign neg_r_in = -{1'b0, r_sat};
    assign r_off   = {1'b0, r_reg};

    assign xs  = {2'b00, cx_reg} + {{(POS_W-OFF_W){dx_reg[OFF_W-1]}}, dx_reg};
    assign ys  = {2'b00, cy_reg} + {{(POS_W-OFF_W){dy_reg[OFF_W-1]}}, dy_reg};
    assign adx = dx_reg[OFF_W-1] ? -dx_reg : dx_reg;
    assign ady = dy_reg[OFF_W-1] ? -dy_reg : dy_reg;
    assign sqx = adx[RAD_W-1:0] * adx[RAD_W-1:0];
    assign sqy = ady[RAD_W-1:0] * ady[RAD_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        out_load   = 1'b0;
        probe_next.vld     = 1'b0;
        probe_next.in_grid = !xs[POS_W-1] && (xs < GW_POS) && !ys[POS_W-1] && (ys < GH_POS);
        probe_next.x       = xs[X_W-1:0];
        probe_next.y       = ys[Y_W-1:0];
        probe_next.dsq     = {1'b0, sqx} + {1'b0, sqy};
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_start)
                begin
                    dx_next    = neg_r_in;
                    dy_next    = neg_r_in;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                probe_next.vld = 1'b1;
                if (dx_reg == r_off)
                begin
                    dx_next = -r_off;
                    dy_next = dy_reg + 1'b1;
                    if (dy_reg == r_off)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            probe_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            r_reg        <= r_sat;
            cx_reg       <= cell_x;
            cy_reg       <= cell_y;
            use_pref_reg <= use_preference;
            pref_reg     <= pref_kind;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_ctrl.we    = 1'b1;
            ram_ctrl.waddr = clr_reg;
            ram_ctrl.wdata = CLASS_WALKABLE;
        end
        else
        begin
            ram_ctrl.we    = accept && (mode == MODE_WRITE)
                             && ({1'b0, cell_x} < (X_W+1)'(GRID_WIDTH))
                             && ({1'b0, cell_y} < (Y_W+1)'(GRID_HEIGHT));
            ram_ctrl.waddr = {cell_y, cell_x};
            ram_ctrl.wdata = cell_class;
        end
        ram_ctrl.raddr = {ys[Y_W-1:0], xs[X_W-1:0]};
    end

    assign probe          = probe_reg;
    assign query.start    = q_start;
    assign query.use_pref = use_pref_reg;
    assign query.pref     = pref_reg;
    assign stat.ready     = (state_reg == ST_IDLE);
    assign stat.out_load  = out_load;
    assign stat.clearing  = (state_reg == ST_CLEAR);

endmodule
`default_nettype wire

/* rtl/core/nrcs_best_unit.sv */
// Shared match and compare unit: checks one probed cell a cycle and keeps the best.
// Depends on nrcs_pkg for kind decoding and structs.
`default_nettype none
module nrcs_best_unit
    import nrcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire query_t             query,
    input  wire probe_t             probe,
    input  wire logic [CLASS_W-1:0] rdata,
    output best_t                   best
);

    best_t             best_reg, best_next;
    logic [KIND_W-1:0] kind;
    logic              match;

    assign kind  = kind_of_class(rdata);
    assign match = probe.vld && probe.in_grid && (kind != KIND_NONE)
                   && (!query.use_pref || (kind == query.pref));

    always_comb
    begin
        best_next = best_reg;
        if (query.start)
        begin
            best_next = '0;
        end
        else if (match && (!best_reg.found || (probe.dsq < best_reg.dsq)))
        begin
            best_next.found = 1'b1;
            best_next.kind  = kind;
            best_next.x     = probe.x;
            best_next.y     = probe.y;
            best_next.dsq   = probe.dsq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule
`default_nettype wire

/* rtl/core/nearest_resource_cell_search.sv */
// Nearest resource cell search: a write word stores one class; a query word
// scans the (2R+1)^2 window one cell per cycle through the single grid read port,
// then drains and loads the result once the output register is free; the next word
// is taken in the cycle after that load. After reset the grid is swept to walkable,
// during which no word is accepted; search_radius resets to 3. Depends on nrcs_pkg,
// nrcs_seq, nrcs_grid_ram and nrcs_best_unit.
`default_nettype none
module nearest_resource_cell_search
    import nrcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // cell_x[5:0], cell_y[11:6], cell_class[14:12], use_preference[15],
    // pref_kind[17:16], zero[23:18]
    input  wire logic [DATA_W-1:0] s_tdata,
    // mode[0]
    input  wire logic [0:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // found[0], found_kind[2:1], found_x[8:3], found_y[14:9], range_sq[23:15]
    output logic [DATA_W-1:0]      m_tdata,
    input  wire logic              cfg_we,
    input  wire logic [RAD_W-1:0]  cfg_wdata
);

    logic [RAD_W-1:0]  radius_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg;
    ram_ctrl_t         ram_ctrl;
    probe_t            probe;
    query_t            query;
    seq_stat_t         stat;
    best_t             best;
    logic [CLASS_W-1:0] rdata;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    nrcs_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .mode           (s_tuser[0]),
        .cell_x         (s_tdata[5:0]),
        .cell_y         (s_tdata[11:6]),
        .cell_class     (s_tdata[14:12]),
        .use_preference (s_tdata[15]),
        .pref_kind      (s_tdata[17:16]),
        .search_radius  (radius_reg),
        .out_free       (out_free),
        .ram_ctrl       (ram_ctrl),
        .probe          (probe),
        .query          (query),
        .stat           (stat)
    );

    nrcs_grid_ram u_ram (
        .clk   (clk),
        .ctrl  (ram_ctrl),
        .rdata (rdata)
    );

    nrcs_best_unit u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .query (query),
        .probe (probe),
        .rdata (rdata),
        .best  (best)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (stat.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RESET_RADIUS;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.out_load)
        begin
            m_tdata_reg <= {best.dsq, best.y, best.x, best.kind, best.found};
        end
    end

    assign s_tready = stat.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_load_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_load |-> !stat.ready)
        else $error("result load while accepting a word");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> (!stat.ready && ram_ctrl.we && !m_tvalid_reg))
        else $error("grid sweep overlaps normal operation");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(stat.out_load))
        else $error("result valid without a load");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best.found |-> (best.dsq <= DIST_W'(2 * MAX_RADIUS * MAX_RADIUS)))
        else $error("best distance beyond window");

endmodule
`default_nettype wire

/* tb/sv/tb_nearest_resource_cell_search.sv */
`timescale 1ns / 1ps
// Self-checking testbench for nearest_resource_cell_search: streams cell writes and window
// queries, predicts every query result from a shadow grid held in a scoreboard class.
// Depends on nrcs_pkg and the nearest_resource_cell_search RTL.
module tb_nearest_resource_cell_search
    import nrcs_pkg::*;
();

    class resource_scoreboard;
        logic [CLASS_W-1:0] shadow_grid [DEPTH];
        int unsigned window_radius;
        best_t nearest_q[$];
        int errors;

        function new();
            foreach (shadow_grid[i])
                shadow_grid[i] = CLASS_WALKABLE;
            window_radius = RESET_RADIUS;
            errors = 0;
        endfunction

        function void set_radius(logic [RAD_W-1:0] value);
            window_radius = (value > MAX_RADIUS) ? MAX_RADIUS : value;
        endfunction

        function int pending();
            return nearest_q.size();
        endfunction

        function void note_word(logic mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                logic [CLASS_W-1:0] cls, logic use_pref,
                                logic [KIND_W-1:0] pref);
            best_t hit;
            int r;
            int px;
            int py;
            int d;
            int best_d;
            logic [KIND_W-1:0] kind;
            if (mode == MODE_WRITE)
            begin
                shadow_grid[int'(y) * GRID_WIDTH + int'(x)] = cls;
                return;
            end
            r = window_radius;
            hit = '0;
            best_d = 0;
            for (int dy = -r; dy <= r; dy++)
            begin
                for (int dx = -r; dx <= r; dx++)
                begin
                    px = int'(x) + dx;
                    py = int'(y) + dy;
                    if (px < 0 || py < 0 || px >= GRID_WIDTH || py >= GRID_HEIGHT)
                        continue;
                    case (shadow_grid[py * GRID_WIDTH + px])
                        CLASS_TREE:     kind = KIND_TREE;
                        CLASS_BOULDER:  kind = KIND_BOULDER;
                        CLASS_IRON_ORE: kind = KIND_IRON_ORE;
                        default:        kind = KIND_NONE;
                    endcase
                    if (kind == KIND_NONE)
                        continue;
                    if (use_pref && kind != pref)
                        continue;
                    d = dx * dx + dy * dy;
                    if (!hit.found || d < best_d)
                    begin
                        best_d    = d;
                        hit.found = 1'b1;
                        hit.kind  = kind;
                        hit.x     = X_W'(px);
                        hit.y     = Y_W'(py);
                        hit.dsq   = (d > 511) ? 9'd511 : DIST_W'(d);
                    end
                end
            end
            nearest_q.push_back(hit);
        endfunction

        task report(string msg);
            if (errors < 200)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] word);
            best_t want;
            best_t got;
            got.found = word[0];
            got.kind  = word[2:1];
            got.x     = word[8:3];
            got.y     = word[14:9];
            got.dsq   = word[23:15];
            if (nearest_q.size() == 0)
            begin
                report($sformatf("result word %h with no query pending", word));
                return;
            end
            want = nearest_q.pop_front();
            if (got.found != want.found)
                report($sformatf("found %0d, want %0d", got.found, want.found));
            if (got.kind != want.kind)
                report($sformatf("found_kind %0d, want %0d", got.kind, want.kind));
            if (got.x != want.x)
                report($sformatf("found_x %0d, want %0d", got.x, want.x));
            if (got.y != want.y)
                report($sformatf("found_y %0d, want %0d", got.y, want.y));
            if (got.dsq != want.dsq)
                report($sformatf("range_sq %0d, want %0d", got.dsq, want.dsq));
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int CFG_SETTLE     = 4;
    localparam int MAX_GAP        = 17;

    localparam logic [CLASS_W-1:0] CLASS_BLOCKED = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_FOREST  = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_SPARE_A = 3'd6;
    localparam logic [CLASS_W-1:0] CLASS_SPARE_B = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              cfg_we;
    logic [RAD_W-1:0]  cfg_wdata;

    logic src_steady  = 1'b0;
    logic sink_steady = 1'b0;
    int   idle_cycles = 0;

    int phase_radius [12] = '{0, 15, 1, 2, 4, 5, 6, 8, 12, 3, 7, 1};

    resource_scoreboard sb;

    nearest_resource_cell_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int gap;
        m_tready = 1'b0;
        forever
        begin
            gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata);
        end
    end

    task automatic send_word(input logic mode, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y, input logic [CLASS_W-1:0] cls,
                             input logic use_pref, input logic [KIND_W-1:0] pref);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(DATA_W-18){1'b0}}, pref, use_pref, cls, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(mode, x, y, cls, use_pref, pref);
    endtask

    task automatic write_cell(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                              input logic [CLASS_W-1:0] cls);
        send_word(MODE_WRITE, x, y, cls, 1'b0, KIND_TREE);
    endtask

    task automatic query_cell(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                              input logic use_pref, input logic [KIND_W-1:0] pref);
        send_word(MODE_QUERY, x, y, CLASS_WALKABLE, use_pref, pref);
    endtask

    // hold the sender until every pending query has answered, then let the block settle
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_radius(value);
    endtask

    task automatic run_phase(input int words, input int radius);
        int fx;
        int fy;
        int span;
        int pick;
        pick = $urandom_range(0, 3);
        fx = (pick == 0) ? 0 : (pick == 1) ? GRID_WIDTH - 1 : $urandom_range(0, GRID_WIDTH - 1);
        pick = $urandom_range(0, 3);
        fy = (pick == 0) ? 0 : (pick == 1) ? GRID_HEIGHT - 1 : $urandom_range(0, GRID_HEIGHT - 1);
        span = radius + 3;
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < words; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_word(MODE_WRITE,
                          X_W'(fx + $urandom_range(0, 2 * span) - span),
                          Y_W'(fy + $urandom_range(0, 2 * span) - span),
                          ($urandom_range(0, 9) < 6) ?
                              CLASS_W'($urandom_range(CLASS_TREE, CLASS_IRON_ORE)) :
                              CLASS_W'($urandom()),
                          1'($urandom()), KIND_W'($urandom()));
            else if (pick < 92)
                send_word(MODE_QUERY,
                          X_W'(fx + $urandom_range(0, 2 * radius + 4) - radius - 2),
                          Y_W'(fy + $urandom_range(0, 2 * radius + 4) - radius - 2),
                          CLASS_W'($urandom()), 1'($urandom()), KIND_W'($urandom()));
            else
                send_word(1'($urandom()), X_W'($urandom()), Y_W'($urandom()),
                          CLASS_W'($urandom()), 1'($urandom()), KIND_W'($urandom()));
            if ($urandom_range(0, 59) == 0)
                wait_results_done();
            if ($urandom_range(0, 39) == 0)
                src_steady = ~src_steady;
            if ($urandom_range(0, 39) == 0)
                sink_steady = ~sink_steady;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_WRITE;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        query_cell(0, 0, 1'b0, KIND_TREE);
        write_cell(0, 0, CLASS_TREE);
        write_cell(1, 0, CLASS_IRON_ORE);
        write_cell(0, 1, CLASS_SPARE_B);
        write_cell(2, 2, CLASS_SPARE_A);
        write_cell(63, 63, CLASS_BOULDER);
        write_cell(3, 3, CLASS_FOREST);
        write_cell(0, 2, CLASS_BLOCKED);
        query_cell(0, 0, 1'b0, KIND_TREE);
        query_cell(0, 0, 1'b1, KIND_IRON_ORE);
        query_cell(0, 0, 1'b1, KIND_BOULDER);
        query_cell(63, 63, 1'b1, KIND_NONE);
        query_cell(63, 63, 1'b0, KIND_NONE);
        write_cell(10, 9, CLASS_TREE);
        write_cell(9, 10, CLASS_BOULDER);
        query_cell(10, 10, 1'b0, KIND_TREE);
        query_cell(10, 10, 1'b1, KIND_BOULDER);
        write_cell(10, 9, CLASS_WALKABLE);
        write_cell(9, 10, CLASS_WALKABLE);
        query_cell(63, 0, 1'b0, KIND_TREE);
        query_cell(2, 1, 1'b0, KIND_TREE);
        write_cell(63, 63, CLASS_SPARE_B);
        query_cell(63, 63, 1'b0, KIND_TREE);
        wait_results_done();

        foreach (phase_radius[p])
        begin
            write_radius(RAD_W'(phase_radius[p]));
            run_phase((phase_radius[p] >= 12) ? 30 : 100, phase_radius[p]);
            wait_results_done();
        end

        repeat (32) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/core/nrcs_pkg.sv
rtl/core/nrcs_grid_ram.sv
rtl/core/nrcs_seq.sv
rtl/core/nrcs_best_unit.sv
rtl/core/nearest_resource_cell_search.sv
tb/sv/tb_nearest_resource_cell_search.sv
